// File: rtl/core/hrdp_pkg.sv
// Shared types, element codes and field widths for the HRD parameters parser.
`timescale 1ns / 1ps

package hrdp_pkg;

   // Parse phase; an active phase equals the code of the element being read.
   typedef enum logic [4:0] {
      PH_NAL_FLAG          = 5'd0,
      PH_VCL_FLAG          = 5'd1,
      PH_SUB_PIC_FLAG      = 5'd2,
      PH_TICK_DIVISOR      = 5'd3,
      PH_DU_DELAY_INC_LEN  = 5'd4,
      PH_SUB_PIC_SEI_FLAG  = 5'd5,
      PH_DPB_DELAY_DU_LEN  = 5'd6,
      PH_BIT_RATE_SCALE    = 5'd7,
      PH_CPB_SIZE_SCALE    = 5'd8,
      PH_CPB_SIZE_DU_SCALE = 5'd9,
      PH_INIT_DELAY_LEN    = 5'd10,
      PH_AU_DELAY_LEN      = 5'd11,
      PH_DPB_DELAY_LEN     = 5'd12,
      PH_FIXED_GENERAL     = 5'd13,
      PH_FIXED_WITHIN_CVS  = 5'd14,
      PH_ELEM_DURATION     = 5'd15,
      PH_LOW_DELAY         = 5'd16,
      PH_CPB_CNT           = 5'd17,
      PH_BIT_RATE          = 5'd18,
      PH_CPB_SIZE          = 5'd19,
      PH_CPB_SIZE_DU       = 5'd20,
      PH_BIT_RATE_DU       = 5'd21,
      PH_CBR_FLAG          = 5'd22,
      PH_DONE              = 5'd30,
      PH_IDLE              = 5'd31
   } phase_type;

   typedef enum logic {
      KIND_NAL = 1'b0,
      KIND_VCL = 1'b1
   } kind_type;

   typedef struct packed {
      logic [4:0]  element_code;
      logic [2:0]  sub_layer;
      logic [4:0]  cpb_index;
      logic        hrd_kind;
      logic [31:0] element_value;
      logic        last;
      logic        error;
   } hrdp_result_type;

   // Width of a u(n) element; zero marks an Exp-Golomb ue(v) element.
   function automatic logic [3:0] elem_width(phase_type code);
      logic [3:0] w;
      case (code)
         PH_NAL_FLAG, PH_VCL_FLAG, PH_SUB_PIC_FLAG, PH_SUB_PIC_SEI_FLAG,
         PH_FIXED_GENERAL, PH_FIXED_WITHIN_CVS, PH_LOW_DELAY,
         PH_CBR_FLAG:                                  w = 4'd1;
         PH_TICK_DIVISOR:                              w = 4'd8;
         PH_DU_DELAY_INC_LEN, PH_DPB_DELAY_DU_LEN, PH_INIT_DELAY_LEN,
         PH_AU_DELAY_LEN, PH_DPB_DELAY_LEN:            w = 4'd5;
         PH_BIT_RATE_SCALE, PH_CPB_SIZE_SCALE,
         PH_CPB_SIZE_DU_SCALE:                         w = 4'd4;
         default:                                      w = 4'd0;
      endcase
      return w;
   endfunction

endpackage

// File: rtl/core/hrd_parameters_parser.sv
// Top level of the bit-serial HRD parameters parser.
`timescale 1ns / 1ps
//
// Usage:
//   req_*  : one stream bit per transfer, most significant bit first. Raise
//            req_start_req with the first bit of a structure; common-info and
//            sub-layer count are sampled on that transfer. A start during a
//            structure abandons it and restarts.
//   rsp_*  : one transfer per completed syntax element, tagged with element
//            code, sub-layer, CPB index and NAL/VCL kind; rsp_last marks the
//            end of the structure, rsp_error an over-long Exp-Golomb prefix.
//   Output: the result of the bit that completes an element is registered
//            in the output or skid register before it reaches rsp_*.
//   Throughput: one bit per cycle while req_ready is high; the per-bit state
//            walk is a single pass of logic into the state and result registers.
//   Stall: an output register plus a skid register hold up to two results;
//            req_ready drops only while both are full.
//   Reset: synchronous; the parser goes idle, buffers empty, no clearing
//            pass. Bits outside a structure are dropped without result.
//
module hrd_parameters_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_stream_bit,
   input  logic        req_start_req,
   input  logic        req_common_info_present,
   input  logic [2:0]  req_max_sub_layers_minus1,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_element_code,
   output logic [2:0]  rsp_sub_layer,
   output logic [4:0]  rsp_cpb_index,
   output logic        rsp_hrd_kind,
   output logic [31:0] rsp_element_value,
   output logic        rsp_last,
   output logic        rsp_error
);
   import hrdp_pkg::*;

   logic            accept;
   logic            res_valid;
   hrdp_result_type res, rsp_data;

   // advance the parser on each input transfer
   assign accept = req_valid && req_ready;

   hrdp_parser u_parser (
      .clock                 (clock),
      .reset                 (reset),
      .accept                (accept),
      .stream_bit            (req_stream_bit),
      .start_req             (req_start_req),
      .common_info_present   (req_common_info_present),
      .max_sub_layers_minus1 (req_max_sub_layers_minus1),
      .res_valid             (res_valid),
      .res                   (res)
   );

   // hold results here while the receiver stalls
   hrdp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .in_ready  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_element_code  = rsp_data.element_code;
   assign rsp_sub_layer     = rsp_data.sub_layer;
   assign rsp_cpb_index     = rsp_data.cpb_index;
   assign rsp_hrd_kind      = rsp_data.hrd_kind;
   assign rsp_element_value = rsp_data.element_value;
   assign rsp_last          = rsp_data.last;
   assign rsp_error         = rsp_data.error;

endmodule

// File: rtl/core/hrdp_parser.sv
// Syntax walker: consumes one stream bit per transfer and flags completed elements.
`timescale 1ns / 1ps

module hrdp_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic                     stream_bit,
   input  logic                     start_req,
   input  logic                     common_info_present,
   input  logic [2:0]               max_sub_layers_minus1,
   output logic                     res_valid,
   output hrdp_pkg::hrdp_result_type res
);
   import hrdp_pkg::*;

   phase_type   phase_ff, phase_in, cur_phase, nxt_phase;
   logic [2:0]  sub_ff, sub_in, cur_sub, sub_adv;
   logic [2:0]  limit_ff, limit_in;
   logic [4:0]  cpb_ff, cpb_in, cur_cpb, cpb_adv;
   logic [4:0]  cpbmax_ff, cpbmax_in, cur_cpbmax, cpbmax_adv;
   kind_type    kind_ff, kind_in, cur_kind, kind_adv;
   logic        nal_ff, nal_in, nal_adv;
   logic        vcl_ff, vcl_in, vcl_adv;
   logic        subpic_ff, subpic_in, subpic_adv;
   logic [31:0] acc_ff, acc_in, cur_acc, acc_sh, value;
   logic [4:0]  rem_ff, rem_in, cur_rem, rem_dec;
   logic [4:0]  lzc_ff, lzc_in, cur_lzc;
   logic        sfx_ff, sfx_in, cur_sfx;
   logic        done, err;

   // Start overrides the held position with a fresh structure.
   always_comb begin
      if (start_req) begin
         cur_phase  = common_info_present ? PH_NAL_FLAG : PH_FIXED_GENERAL;
         cur_sub    = 3'd0;
         cur_cpb    = 5'd0;
         cur_cpbmax = 5'd0;
         cur_kind   = KIND_NAL;
         cur_acc    = 32'd0;
         cur_lzc    = 5'd0;
         cur_sfx    = 1'b0;
         cur_rem    = {1'b0, elem_width(cur_phase)};
         limit_in   = max_sub_layers_minus1;
      end else begin
         cur_phase  = phase_ff;
         cur_sub    = sub_ff;
         cur_cpb    = cpb_ff;
         cur_cpbmax = cpbmax_ff;
         cur_kind   = kind_ff;
         cur_acc    = acc_ff;
         cur_lzc    = lzc_ff;
         cur_sfx    = sfx_ff;
         cur_rem    = rem_ff;
         limit_in   = limit_ff;
      end
   end

   // Bit-level field assembly.
   always_comb begin
      acc_sh  = {cur_acc[30:0], stream_bit};
      rem_dec = cur_rem - 5'd1;
      acc_in  = cur_acc;
      rem_in  = cur_rem;
      lzc_in  = cur_lzc;
      sfx_in  = cur_sfx;
      done    = 1'b0;
      err     = 1'b0;
      value   = 32'd0;
      if (cur_phase != PH_IDLE) begin
         if (elem_width(cur_phase) != 4'd0) begin
            acc_in = acc_sh;
            rem_in = rem_dec;
            if (rem_dec == 5'd0) begin
               done  = 1'b1;
               value = acc_sh;
            end
         end else if (!cur_sfx) begin
            if (!stream_bit) begin
               if (cur_lzc == 5'd31) begin
                  err = 1'b1;
               end else begin
                  lzc_in = cur_lzc + 5'd1;
               end
            end else if (cur_lzc == 5'd0) begin
               done = 1'b1;
            end else begin
               sfx_in = 1'b1;
               rem_in = cur_lzc;
               acc_in = 32'd0;
            end
         end else begin
            acc_in = acc_sh;
            rem_in = rem_dec;
            if (rem_dec == 5'd0) begin
               done  = 1'b1;
               // suffix is below 2^lzc, so OR places the implied leading one
               value = (acc_sh | (32'd1 << cur_lzc)) - 32'd1;
            end
         end
      end
   end

   // Next element after a completed one.
   always_comb begin
      nxt_phase  = PH_DONE;
      sub_adv    = cur_sub;
      cpb_adv    = cur_cpb;
      cpbmax_adv = cur_cpbmax;
      kind_adv   = cur_kind;
      nal_adv    = nal_ff;
      vcl_adv    = vcl_ff;
      subpic_adv = subpic_ff;
      case (cur_phase)
         PH_NAL_FLAG: begin
            nal_adv   = value[0];
            nxt_phase = PH_VCL_FLAG;
         end
         PH_VCL_FLAG: begin
            vcl_adv = value[0];
            if (nal_ff || value[0]) begin
               nxt_phase = PH_SUB_PIC_FLAG;
            end else begin
               subpic_adv = 1'b0;
               nxt_phase  = PH_FIXED_GENERAL;
            end
         end
         PH_SUB_PIC_FLAG: begin
            subpic_adv = value[0];
            nxt_phase  = value[0] ? PH_TICK_DIVISOR : PH_BIT_RATE_SCALE;
         end
         PH_TICK_DIVISOR:      nxt_phase = PH_DU_DELAY_INC_LEN;
         PH_DU_DELAY_INC_LEN:  nxt_phase = PH_SUB_PIC_SEI_FLAG;
         PH_SUB_PIC_SEI_FLAG:  nxt_phase = PH_DPB_DELAY_DU_LEN;
         PH_DPB_DELAY_DU_LEN:  nxt_phase = PH_BIT_RATE_SCALE;
         PH_BIT_RATE_SCALE:    nxt_phase = PH_CPB_SIZE_SCALE;
         PH_CPB_SIZE_SCALE:
            nxt_phase = subpic_ff ? PH_CPB_SIZE_DU_SCALE : PH_INIT_DELAY_LEN;
         PH_CPB_SIZE_DU_SCALE: nxt_phase = PH_INIT_DELAY_LEN;
         PH_INIT_DELAY_LEN:    nxt_phase = PH_AU_DELAY_LEN;
         PH_AU_DELAY_LEN:      nxt_phase = PH_DPB_DELAY_LEN;
         PH_DPB_DELAY_LEN:     nxt_phase = PH_FIXED_GENERAL;
         PH_FIXED_GENERAL:
            nxt_phase = value[0] ? PH_ELEM_DURATION : PH_FIXED_WITHIN_CVS;
         PH_FIXED_WITHIN_CVS:
            nxt_phase = value[0] ? PH_ELEM_DURATION : PH_LOW_DELAY;
         PH_ELEM_DURATION:     nxt_phase = PH_CPB_CNT;
         PH_LOW_DELAY, PH_CPB_CNT: begin
            if (cur_phase == PH_LOW_DELAY && !value[0]) begin
               nxt_phase = PH_CPB_CNT;
            end else begin
               if (cur_phase == PH_LOW_DELAY) begin
                  cpbmax_adv = 5'd0;
               end else begin
                  cpbmax_adv = (|value[31:5]) ? 5'd31 : value[4:0];
               end
               cpb_adv = 5'd0;
               if (nal_ff) begin
                  kind_adv  = KIND_NAL;
                  nxt_phase = PH_BIT_RATE;
               end else if (vcl_ff) begin
                  kind_adv  = KIND_VCL;
                  nxt_phase = PH_BIT_RATE;
               end else if (cur_sub < limit_in) begin
                  sub_adv   = cur_sub + 3'd1;
                  nxt_phase = PH_FIXED_GENERAL;
               end
            end
         end
         PH_BIT_RATE:    nxt_phase = PH_CPB_SIZE;
         PH_CPB_SIZE:    nxt_phase = subpic_ff ? PH_CPB_SIZE_DU : PH_CBR_FLAG;
         PH_CPB_SIZE_DU: nxt_phase = PH_BIT_RATE_DU;
         PH_BIT_RATE_DU: nxt_phase = PH_CBR_FLAG;
         PH_CBR_FLAG: begin
            if (cur_cpb < cur_cpbmax) begin
               cpb_adv   = cur_cpb + 5'd1;
               nxt_phase = PH_BIT_RATE;
            end else if (cur_kind == KIND_NAL && vcl_ff) begin
               kind_adv  = KIND_VCL;
               cpb_adv   = 5'd0;
               nxt_phase = PH_BIT_RATE;
            end else if (cur_sub < limit_in) begin
               sub_adv   = cur_sub + 3'd1;
               nxt_phase = PH_FIXED_GENERAL;
            end
         end
         default: nxt_phase = PH_DONE;
      endcase
   end

   // Merge element completion into the state update.
   always_comb begin
      phase_in  = cur_phase;
      sub_in    = cur_sub;
      cpb_in    = cur_cpb;
      cpbmax_in = cur_cpbmax;
      kind_in   = cur_kind;
      nal_in    = nal_ff;
      vcl_in    = vcl_ff;
      subpic_in = subpic_ff;
      if (err) begin
         phase_in = PH_IDLE;
      end else if (done) begin
         sub_in    = sub_adv;
         cpb_in    = cpb_adv;
         cpbmax_in = cpbmax_adv;
         kind_in   = kind_adv;
         nal_in    = nal_adv;
         vcl_in    = vcl_adv;
         subpic_in = subpic_adv;
         phase_in  = (nxt_phase == PH_DONE) ? PH_IDLE : nxt_phase;
      end
   end

   // Result fields carry the indices in force before the advance.
   always_comb begin
      res_valid         = accept && (done || err);
      res.element_code  = cur_phase;
      res.sub_layer     = (cur_phase >= PH_FIXED_GENERAL) ? cur_sub : 3'd0;
      res.cpb_index     = (cur_phase >= PH_BIT_RATE) ? cur_cpb : 5'd0;
      res.hrd_kind      = (cur_phase >= PH_BIT_RATE) ? cur_kind : 1'b0;
      res.element_value = err ? 32'd0 : value;
      res.last          = err || (nxt_phase == PH_DONE);
      res.error         = err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         sub_ff    <= 3'd0;
         limit_ff  <= 3'd0;
         cpb_ff    <= 5'd0;
         cpbmax_ff <= 5'd0;
         kind_ff   <= KIND_NAL;
         nal_ff    <= 1'b0;
         vcl_ff    <= 1'b0;
         subpic_ff <= 1'b0;
         rem_ff    <= 5'd0;
         lzc_ff    <= 5'd0;
         sfx_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         sub_ff    <= sub_in;
         limit_ff  <= limit_in;
         cpb_ff    <= cpb_in;
         cpbmax_ff <= cpbmax_in;
         kind_ff   <= kind_in;
         nal_ff    <= nal_in;
         vcl_ff    <= vcl_in;
         subpic_ff <= subpic_in;
         if (done && !err) begin
            rem_ff <= {1'b0, elem_width(nxt_phase)};
            lzc_ff <= 5'd0;
            sfx_ff <= 1'b0;
         end else begin
            rem_ff <= rem_in;
            lzc_ff <= lzc_in;
            sfx_ff <= sfx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         acc_ff <= (done && !err) ? 32'd0 : acc_in;
      end
   end

endmodule

// File: rtl/core/hrdp_out_buf.sv
// Two-entry result buffer: output register plus skid register.
`timescale 1ns / 1ps

module hrdp_out_buf (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  hrdp_pkg::hrdp_result_type push_data,
   output logic                      in_ready,
   output logic                      out_valid,
   input  logic                      out_ready,
   output hrdp_pkg::hrdp_result_type out_data
);
   import hrdp_pkg::*;

   hrdp_result_type out_ff, out_in, skid_ff, skid_in;
   logic            out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   logic            drain;

   assign drain     = out_valid_ff && out_ready;
   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (drain) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else if (push) begin
            out_in = push_data;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff) begin
            out_in       = push_data;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule

// File: rtl/core/hrdp_checker.sv
// Port-level assertions for the HRD parameters parser, bound to the top level.
`timescale 1ns / 1ps

module hrdp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [4:0]  rsp_element_code,
   input logic [2:0]  rsp_sub_layer,
   input logic [4:0]  rsp_cpb_index,
   input logic        rsp_hrd_kind,
   input logic [31:0] rsp_element_value,
   input logic        rsp_last,
   input logic        rsp_error
);

   // an aborted parse closes the structure with a zero value
   a_error_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_last && rsp_element_value == 32'd0)
      else $error("error result not final or nonzero");

   // common elements carry no sub-layer, CPB or kind tags
   a_common_tags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_element_code < 5'd13 |->
         rsp_sub_layer == 3'd0 && rsp_cpb_index == 5'd0 && !rsp_hrd_kind)
      else $error("common element carries tags");

   // element codes stay within the syntax
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_element_code <= 5'd22)
      else $error("element code out of range");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_element_value)
         && $stable(rsp_element_code))
      else $error("stalled result changed");

endmodule

bind hrd_parameters_parser hrdp_checker u_hrdp_checker (.*);
